>>> rtl/core/sliding_window_log_rate_limiter_defines.svh
// Assertion macros shared by the rate limiter RTL.
`ifndef SLIDING_WINDOW_LOG_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_LOG_RATE_LIMITER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define SWL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SWL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SWL_ASSERT(lbl, prop, msg)
`define SWL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/swlrl_pkg.sv
// Shared constants for the sliding window log rate limiter.
`default_nettype none
package swlrl_pkg;
    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_RULE  = 1'b1;

    localparam int TOOL_W = 4;
    localparam int NOW_W  = 32;
    localparam int MAX_W  = 5;
    localparam int WIN_W  = 16;
    localparam int CNT_W  = 5;
endpackage
`default_nettype wire

>>> rtl/core/swlrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swlrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/core/sliding_window_log_rate_limiter.sv
// Per-key sliding window log rate limiter: rule store, timestamp rings, sequencer.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per request:
// a rule write (req_type 1) stores present / max calls / window for a key, a
// check (req_type 0) tests a call at now_seconds against the key's rule.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// limited, recorded and the key's history count afterwards.
// One request is in flight at a time. After the accept a check reads its key's
// metadata (S_META), walks the ring front in S_PRUNE with one history RAM read
// per step (each pop plus the read that ends the walk; at most HIST_DEPTH
// steps), updates the key's metadata and ring in S_DECIDE and presents its
// result in S_RESP; the next request is taken once the block is back in S_IDLE.
// Rule writes, checks without a rule and keys >= NUM_KEYS skip walk and update
// and go from S_META straight to S_RESP.
// Reset clears the rule-valid bits and marks every key's ring empty; the RAMs
// themselves are not cleared, so the block is ready right after reset.
// While the receiver stalls, the result waits in the output register and the
// next request is still accepted and worked on; it then holds in its result
// cycle until the output register frees up.
`default_nettype none
`include "sliding_window_log_rate_limiter_defines.svh"
module sliding_window_log_rate_limiter
    import swlrl_pkg::*;
#(
    parameter int NUM_KEYS   = 16,
    parameter int HIST_DEPTH = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [TOOL_W-1:0] i_tool_index,
    input  wire logic [NOW_W-1:0]  i_now_seconds,
    input  wire logic              i_rule_present,
    input  wire logic [MAX_W-1:0]  i_rule_max_calls,
    input  wire logic [WIN_W-1:0]  i_rule_window_seconds,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_limited,
    output logic                   o_recorded,
    output logic [CNT_W-1:0]       o_calls_in_window
);
    localparam int KW = $clog2(NUM_KEYS);
    localparam int SW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FW = $clog2(HIST_DEPTH + 1);
    localparam int PW = FW + 1;
    localparam int META_DEPTH = 1 << KW;
    localparam int HIST_WORDS = 1 << (KW + SW);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_META   = 3'd1;
    localparam logic [2:0] S_PRUNE  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    typedef struct packed {
        logic [MAX_W-1:0] limit;
        logic [WIN_W-1:0] window;
        logic [SW-1:0]    head;
        logic [FW-1:0]    fill;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    // control
    logic [2:0]          r_state;
    logic                r_out_valid;
    logic [NUM_KEYS-1:0] r_rule_valid;
    logic [NUM_KEYS-1:0] r_meta_ok;   // key's metadata entry has been written

    // request and working registers
    logic                 r_req;
    logic [KW-1:0]        r_key;
    logic                 r_in_range;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_present;
    logic [MAX_W-1:0]     r_max;
    logic [WIN_W-1:0]     r_win_new;
    logic [MAX_W-1:0]     r_lim_raw;
    logic [WIN_W-1:0]     r_win_rule;
    logic [FW-1:0]        r_lim_sat;
    logic [TIME_BITS-1:0] r_cutoff;
    logic [SW-1:0]        r_head;
    logic [FW-1:0]        r_fill;
    logic                 r_res_limited;
    logic                 r_res_recorded;
    logic [CNT_W-1:0]     r_res_count;
    logic                 r_out_limited;
    logic                 r_out_recorded;
    logic [CNT_W-1:0]     r_out_count;

    // datapath
    logic                 w_in_acc;
    logic                 w_out_load;
    t_meta                w_meta_rd;
    t_meta                w_meta_wd;
    logic [META_W-1:0]    w_meta_rdata;
    logic                 w_meta_we;
    logic [TIME_BITS-1:0] w_hist_rd;
    logic                 w_hist_we;
    logic [KW+SW-1:0]     w_hist_raddr;
    logic [KW+SW-1:0]     w_hist_waddr;
    logic                 w_ok;
    logic [SW-1:0]        w_head;
    logic [FW-1:0]        w_fill;
    logic [FW-1:0]        w_lim_sat;
    logic [TIME_BITS-1:0] w_win_t;
    logic                 w_now_ge;
    logic [TIME_BITS-1:0] w_cutoff;
    logic                 w_pop;
    logic [SW-1:0]        w_head_inc;
    logic [PW-1:0]        w_sum;
    logic [SW-1:0]        w_pos;
    logic                 w_full;
    logic [FW-1:0]        w_fill_new;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    assign w_meta_rd = t_meta'(w_meta_rdata);

    // a key never rule-written reads as an empty ring
    always_comb begin
        w_ok       = r_meta_ok[r_key];
        w_head     = w_ok ? w_meta_rd.head : '0;
        w_fill     = w_ok ? w_meta_rd.fill : '0;
        w_lim_sat  = (32'(w_meta_rd.limit) > HIST_DEPTH) ? FW'(HIST_DEPTH)
                                                         : FW'(w_meta_rd.limit);
        w_win_t    = TIME_BITS'(w_meta_rd.window);
        w_now_ge   = (r_now >= w_win_t);
        w_cutoff   = r_now - w_win_t;
        w_pop      = (w_hist_rd < r_cutoff);
        w_head_inc = (r_head == SW'(HIST_DEPTH - 1)) ? '0 : r_head + SW'(1);
        w_sum      = PW'(r_head) + PW'(r_fill);
        w_pos      = (w_sum >= PW'(HIST_DEPTH)) ? SW'(w_sum - PW'(HIST_DEPTH)) : SW'(w_sum);
        w_full     = (r_fill >= r_lim_sat);
        w_fill_new = w_full ? r_fill : r_fill + FW'(1);
    end

    always_comb begin
        w_meta_we = 1'b0;
        w_meta_wd = '{limit: r_lim_raw, window: r_win_rule, head: r_head, fill: w_fill_new};
        case (r_state)
            S_META: begin
                w_meta_we = r_in_range && (r_req == REQ_RULE);
                w_meta_wd = '{limit: r_max, window: r_win_new, head: w_head, fill: w_fill};
            end
            S_DECIDE: begin
                w_meta_we = 1'b1;
            end
            default: begin
                w_meta_we = 1'b0;
            end
        endcase
    end

    assign w_hist_we    = (r_state == S_DECIDE) && !w_full;
    assign w_hist_waddr = {r_key, w_pos};
    assign w_hist_raddr = {r_key, (r_state == S_PRUNE) ? w_head_inc : w_head};

    swlrl_ram #(
        .WIDTH(META_W),
        .DEPTH(META_DEPTH)
    ) u_meta_ram (
        .i_clk  (i_clk),
        .i_we   (w_meta_we),
        .i_waddr(r_key),
        .i_wdata(w_meta_wd),
        .i_raddr(KW'(i_tool_index)),
        .o_rdata(w_meta_rdata)
    );

    swlrl_ram #(
        .WIDTH(TIME_BITS),
        .DEPTH(HIST_WORDS)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (w_hist_we),
        .i_waddr(w_hist_waddr),
        .i_wdata(r_now),
        .i_raddr(w_hist_raddr),
        .o_rdata(w_hist_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_rule_valid <= '0;
            r_meta_ok    <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req      <= i_req_type;
                        r_key      <= KW'(i_tool_index);
                        r_in_range <= (32'(i_tool_index) < NUM_KEYS);
                        r_now      <= TIME_BITS'(i_now_seconds);
                        r_present  <= i_rule_present;
                        r_max      <= i_rule_max_calls;
                        r_win_new  <= i_rule_window_seconds;
                        r_state    <= S_META;
                    end
                end
                S_META: begin
                    r_res_limited  <= 1'b0;
                    r_res_recorded <= 1'b0;
                    r_res_count    <= r_in_range ? CNT_W'(w_fill) : '0;
                    r_head         <= w_head;
                    r_fill         <= w_fill;
                    r_lim_raw      <= w_meta_rd.limit;
                    r_win_rule     <= w_meta_rd.window;
                    r_lim_sat      <= w_lim_sat;
                    r_cutoff       <= w_cutoff;
                    if (!r_in_range) begin
                        r_state <= S_RESP;
                    end else if (r_req == REQ_RULE) begin
                        r_rule_valid[r_key] <= r_present;
                        r_meta_ok[r_key]    <= 1'b1;
                        r_state             <= S_RESP;
                    end else if (!r_rule_valid[r_key]) begin
                        r_state <= S_RESP;
                    end else if (w_now_ge && (w_fill != '0)) begin
                        r_state <= S_PRUNE;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_PRUNE: begin
                    // head entry read last cycle; pop while older than cutoff
                    if (w_pop) begin
                        r_head <= w_head_inc;
                        r_fill <= r_fill - FW'(1);
                        if (r_fill == FW'(1)) begin
                            r_state <= S_DECIDE;
                        end
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_limited  <= w_full;
                    r_res_recorded <= !w_full;
                    r_res_count    <= CNT_W'(w_fill_new);
                    r_state        <= S_RESP;
                end
                S_RESP: begin
                    if (w_out_load) begin
                        r_out_limited  <= r_res_limited;
                        r_out_recorded <= r_res_recorded;
                        r_out_count    <= r_res_count;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_limited         = r_out_limited;
    assign o_recorded        = r_out_recorded;
    assign o_calls_in_window = r_out_count;

    `SWL_ASSERT(a_accept_to_meta, w_in_acc |=> (r_state == S_META), "accept did not start meta read")
    `SWL_ASSERT(a_prune_nonempty, (r_state == S_PRUNE) |-> (r_fill != '0), "prune on empty ring")
    `SWL_ASSERT(a_fill_bound, (r_state == S_DECIDE) |-> (r_fill <= FW'(HIST_DEPTH)), "fill overflow")
    `SWL_ASSERT(a_out_excl, r_out_valid |-> !(r_out_limited && r_out_recorded), "limited and recorded")
    `SWL_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid, "reset not idle")
endmodule
`default_nettype wire
